[rtl/button_press_classifier_mode_select_assert.svh]
// assertion macros for the button press classifier
`ifndef BUTTON_PRESS_CLASSIFIER_MODE_SELECT_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_MODE_SELECT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define BPC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition implies a consequence on the next clock edge
`define BPC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// shared types, constants and mode tables for the button press classifier
package bpc_pkg;

  localparam logic [5:0] DEBOUNCE_MAX_RST     = 6'd30;
  localparam logic [5:0] PRESS_THRESHOLD_RST  = 6'd29;
  localparam logic [7:0] LONG_HOLD_TICKS_RST  = 8'd255;
  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd244;
  localparam logic [2:0] MODE_RST             = 3'd1;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_MAX     = 2'd0,
    REG_PRESS_THRESHOLD  = 2'd1,
    REG_LONG_HOLD_TICKS  = 2'd2,
    REG_TICKS_PER_SECOND = 2'd3
  } bpc_reg_t;

  typedef struct packed {
    logic [5:0] debounce_max;
    logic [5:0] press_threshold;
    logic [7:0] long_hold_ticks;
    logic [7:0] ticks_per_second;
  } bpc_cfg_t;

  typedef struct packed {
    logic [7:0] tick_count;
    logic [7:0] seconds_count;
    logic [5:0] debounce_count;
    logic [7:0] hold_count;
    logic       press_seen;
    logic       long_seen;
    logic       press_locked;
    logic       press_applied;
    logic [2:0] mode_reg;
  } bpc_state_t;

  // counters and flags clear, mode starts at 1
  localparam bpc_state_t STATE_RST = '{8'd0, 8'd0, 6'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                       MODE_RST};

  typedef struct packed {
    logic [2:0] current_mode;
    logic       short_press;
    logic       long_press;
    logic [7:0] idle_seconds;
  } bpc_result_t;

  function automatic logic [2:0] short_next(input logic [2:0] mode);
    logic [2:0] nxt;
    case (mode)
      3'd0:    nxt = 3'd1;
      3'd1:    nxt = 3'd2;
      3'd2:    nxt = 3'd1;
      3'd3:    nxt = 3'd1;
      3'd4:    nxt = 3'd2;
      default: nxt = mode;
    endcase
    return nxt;
  endfunction

  function automatic logic [2:0] long_next(input logic [2:0] mode);
    logic [2:0] nxt;
    case (mode)
      3'd1:    nxt = 3'd3;
      3'd2:    nxt = 3'd4;
      3'd3:    nxt = 3'd1;
      3'd4:    nxt = 3'd2;
      default: nxt = mode;
    endcase
    return nxt;
  endfunction

endpackage

[rtl/bpc_step.sv]
// one tick of prescaler, debounce, press classification and mode update
module bpc_step import bpc_pkg::*; (
  input  bpc_cfg_t    cfg,
  input  bpc_state_t  state,
  input  logic        released,
  input  logic        asleep,
  output bpc_state_t  state_next,
  output bpc_result_t result
);

  always_comb begin
    bpc_state_t s;
    logic       short_out;
    logic       long_out;
    s         = state;
    short_out = 1'b0;
    long_out  = 1'b0;

    // tick prescaler
    s.tick_count = s.tick_count + 8'd1;
    if (s.tick_count > cfg.ticks_per_second) begin
      s.tick_count    = 8'd0;
      s.seconds_count = s.seconds_count + 8'd1;
    end

    // integrating debounce
    if (released) begin
      if (s.debounce_count != 6'd0) begin
        s.debounce_count = s.debounce_count - 6'd1;
      end
    end else if (s.debounce_count < cfg.debounce_max && !s.press_locked) begin
      s.debounce_count = s.debounce_count + 6'd1;
    end

    if (asleep) begin
      s.debounce_count = 6'd0;
      s.hold_count     = 8'd0;
    end

    // press detection and hold timing
    if (s.debounce_count >= cfg.press_threshold && !s.press_locked) begin
      s.press_seen = 1'b1;
      if (s.hold_count < cfg.long_hold_ticks) begin
        s.hold_count = s.hold_count + 8'd1;
      end
      if (s.hold_count >= cfg.long_hold_ticks) begin
        s.long_seen      = 1'b1;
        s.press_locked   = 1'b1;
        s.hold_count     = 8'd0;
        s.debounce_count = 6'd0;
      end
      if (released) begin
        s.press_locked   = 1'b1;
        s.hold_count     = 8'd0;
        s.debounce_count = 6'd0;
      end
    end

    // apply a settled press
    if (s.press_locked && !s.press_applied) begin
      s.seconds_count = 8'd0;
      if (s.press_seen && !s.long_seen) begin
        s.mode_reg = short_next(s.mode_reg);
        short_out  = 1'b1;
      end else if (s.press_seen && s.long_seen) begin
        s.mode_reg = long_next(s.mode_reg);
        long_out   = 1'b1;
      end
      s.press_applied = 1'b1;
    end

    if (s.press_applied && released) begin
      s.press_seen    = 1'b0;
      s.long_seen     = 1'b0;
      s.press_locked  = 1'b0;
      s.press_applied = 1'b0;
    end

    state_next          = s;
    result.current_mode = s.mode_reg;
    result.short_press  = short_out;
    result.long_press   = long_out;
    result.idle_seconds = s.seconds_count;
  end

endmodule

[rtl/button_press_classifier_mode_select.sv]
// top level: config registers, request register, state and result register
// path: request register, combinational step logic, result register
// throughput: one request per cycle while the result register is not stalled
// a waiting result holds one more request; input stalls once both registers are full
// reset: synchronous, active high; config returns to defaults, mode to 1
// counters and press flags clear, request and result registers go empty
`include "button_press_classifier_mode_select_assert.svh"

module button_press_classifier_mode_select import bpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       button_released,
  input  logic       asleep,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] current_mode,
  output logic       short_press,
  output logic       long_press,
  output logic [7:0] idle_seconds
);

  bpc_cfg_t    cfg;
  bpc_state_t  state;
  bpc_state_t  state_next;
  bpc_result_t step_result;
  bpc_result_t result;

  logic req_valid;
  logic req_released;
  logic req_asleep;
  logic advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_max     <= DEBOUNCE_MAX_RST;
      cfg.press_threshold  <= PRESS_THRESHOLD_RST;
      cfg.long_hold_ticks  <= LONG_HOLD_TICKS_RST;
      cfg.ticks_per_second <= TICKS_PER_SECOND_RST;
    end else if (cfg_write) begin
      case (bpc_reg_t'(cfg_index))
        REG_DEBOUNCE_MAX:     cfg.debounce_max     <= cfg_data[5:0];
        REG_PRESS_THRESHOLD:  cfg.press_threshold  <= cfg_data[5:0];
        REG_LONG_HOLD_TICKS:  cfg.long_hold_ticks  <= cfg_data;
        REG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_released <= button_released;
      req_asleep   <= asleep;
    end
  end

  bpc_step u_step (
    .cfg        (cfg),
    .state      (state),
    .released   (req_released),
    .asleep     (req_asleep),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RST;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign current_mode = result.current_mode;
  assign short_press  = result.short_press;
  assign long_press   = result.long_press;
  assign idle_seconds = result.idle_seconds;

  `BPC_ASSERT_ALWAYS(a_mode_range, state.mode_reg != 3'd0 && state.mode_reg <= 3'd4, "bad mode")
  `BPC_ASSERT_ALWAYS(a_one_class, !(out_valid && short_press && long_press), "short and long together")
  `BPC_ASSERT_ALWAYS(a_applied_locked, !state.press_applied || state.press_locked, "applied without lock")
  `BPC_ASSERT_ALWAYS(a_long_seen, !state.long_seen || state.press_seen, "long press without press")
  `BPC_ASSERT_NEXT(a_req_moves, req_valid && !out_valid, out_valid, "request not moved to result")

endmodule
